// ===== hdl/msp_pkg.sv =====
// Shared types, constants and helper functions for the marquee scroll placer.
// Used by msp_front, msp_back and marquee_scroll_placer_top; depends on nothing.
`default_nettype none

package msp_pkg;

  localparam int MAX_COPIES_DEF = 64;
  localparam int CNT_W          = 7;   // holds a copy index up to 64
  localparam int QUEUE_DEPTH    = 2;

  localparam int MODE_W     = 3;
  localparam int STRIP_W    = 12;
  localparam int AREA_W     = 11;
  localparam int STEP_W     = 5;
  localparam int GAP_W      = 9;
  localparam int SCROLL_W   = 13;
  localparam int PERIOD_W   = 13;  // strip plus gap
  localparam int QUOT_W     = AREA_W;
  localparam int LIMIT_W    = 25;  // (quotient + 1) * period
  localparam int POS_W      = 16;
  localparam int ORIGIN_W   = 15;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [MODE_W-1:0] MODE_CENTER   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_END      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MARQUEE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RMARQUEE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LOOP     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RLOOP    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_ALIAS    = 3'd7;  // treated as reverse loop

  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAP     = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]  hm;
    logic [MODE_W-1:0]  vm;
    logic [STRIP_W-1:0] sw;
    logic [STRIP_W-1:0] sh;
    logic [AREA_W-1:0]  aw;
    logic [AREA_W-1:0]  ah;
    logic [STEP_W-1:0]  step;
    logic [GAP_W-1:0]   gap;
  } cfg_t;

  typedef struct packed {
    logic step;  // advance requested and at least one axis scrolls
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fb_t;

  typedef struct packed {
    logic pop;
  } bf_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] cnt;
  } bk_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_STEP,
    BK_PLACE,
    BK_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    PH_PRIM,
    PH_FWD,
    PH_BWD
  } phase_t;

  function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] m);
    return (m == MODE_ALIAS) ? MODE_RLOOP : m;
  endfunction

  function automatic logic is_scroll(input logic [MODE_W-1:0] m);
    return eff_mode(m) >= MODE_MARQUEE;
  endfunction

  function automatic logic is_loop(input logic [MODE_W-1:0] m);
    return eff_mode(m) >= MODE_LOOP;
  endfunction

  function automatic logic signed [POS_W-1:0] place_origin(
    input logic [MODE_W-1:0]   mode,
    input logic [STRIP_W-1:0]  strip,
    input logic [AREA_W-1:0]   area,
    input logic [SCROLL_W-1:0] scroll
  );
    logic signed [POS_W-1:0] s_strip;
    logic signed [POS_W-1:0] s_area;
    logic signed [POS_W-1:0] s_scroll;
    logic signed [POS_W-1:0] r;
    s_strip  = $signed(POS_W'(strip));
    s_area   = $signed(POS_W'(area));
    s_scroll = $signed(POS_W'(scroll));
    case (eff_mode(mode))
      MODE_CENTER: r = $signed(POS_W'(area >> 1)) - $signed(POS_W'(strip >> 1));
      MODE_START:  r = '0;
      MODE_END:    r = s_area - s_strip;
      MODE_MARQUEE, MODE_LOOP: r = s_area - s_scroll;
      default:     r = s_scroll - s_strip;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/msp_front.sv =====
// Front end of the marquee scroll placer: accepts input items, classifies them
// and holds them in a short queue for the back end. Depends on msp_pkg.
`default_nettype none

module msp_front import msp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [0] advance, rest zero
  input  bf_t                  bf,
  output fb_t                  fb
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;
  item_t             item_in;

  // an item steps only when advance is set and some axis scrolls
  assign item_in.step = in_tdata[0] && (is_scroll(cfg.hm) || is_scroll(cfg.vm));

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = bf.pop && (count_r != '0);

  assign fb.valid = (count_r != '0);
  assign fb.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msp_back.sv =====
// Back end of the marquee scroll placer: computes scroll limits with a serial
// divider, steps the scroll positions and emits the strip origins. Uses msp_pkg.
`default_nettype none

module msp_back import msp_pkg::*; #(
  parameter int MAX_COPIES = MAX_COPIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  fb_t                   fb,
  output bf_t                   bf,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [14:0] origin_x, [29:15] origin_y
  output logic                  out_tlast,   // last_copy
  output bk_stat_t              stat
);

  localparam int DCNT_W = $clog2(AREA_W);

  back_state_t             state_r, state_nxt;
  logic                    axis_r, axis_nxt;          // 0 x, 1 y
  logic [PERIOD_W-1:0]     div_rem_r, div_rem_nxt;
  logic [AREA_W-1:0]       div_num_r, div_num_nxt;
  logic [QUOT_W-1:0]       div_quo_r, div_quo_nxt;
  logic [DCNT_W-1:0]       div_cnt_r, div_cnt_nxt;
  logic [LIMIT_W-1:0]      xmax_r, xmax_nxt;
  logic [LIMIT_W-1:0]      ymax_r, ymax_nxt;
  logic [SCROLL_W-1:0]     scroll_x_r, scroll_x_nxt;
  logic [SCROLL_W-1:0]     scroll_y_r, scroll_y_nxt;
  logic signed [POS_W-1:0] cur_r, cur_nxt;
  logic signed [POS_W-1:0] prim_r, prim_nxt;
  logic signed [POS_W-1:0] fix_r, fix_nxt;
  logic                    copy_en_r, copy_en_nxt;
  logic                    copy_y_r, copy_y_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  // divider and limit datapath for the axis in work
  logic [STRIP_W-1:0]      axis_strip;
  logic [AREA_W-1:0]       axis_area;
  logic                    axis_loop;
  logic [PERIOD_W-1:0]     period;
  logic [PERIOD_W-1:0]     divisor;
  logic [PERIOD_W:0]       rem_sh;
  logic [PERIOD_W:0]       rem_sub;
  logic                    rem_ge;
  logic [QUOT_W:0]         quo_inc;
  logic [LIMIT_W-1:0]      limit_val;

  // scroll step
  logic [SCROLL_W-1:0]     sx_step;
  logic [SCROLL_W-1:0]     sy_step;
  logic [SCROLL_W-1:0]     sy_tmp;

  // placement and copy walk
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;
  logic                    loop_x;
  logic                    loop_y;
  logic signed [POS_W-1:0] cp_period;
  logic signed [POS_W-1:0] cp_limit;
  logic                    more_cap;
  logic                    fwd_ok;
  logic                    bwd_prim;
  logic                    bwd_ok;
  logic                    has_next;
  logic signed [POS_W-1:0] next_pos;
  logic signed [POS_W-1:0] ox;
  logic signed [POS_W-1:0] oy;
  logic                    out_free;

  assign axis_strip = axis_r ? cfg.sh : cfg.sw;
  assign axis_area  = axis_r ? cfg.ah : cfg.aw;
  assign axis_loop  = axis_r ? is_loop(cfg.vm) : is_loop(cfg.hm);
  assign period     = PERIOD_W'(axis_strip) + PERIOD_W'(cfg.gap);
  assign divisor    = (period == '0) ? PERIOD_W'(1) : period;
  assign rem_sh     = {div_rem_r, div_num_r[AREA_W-1]};
  assign rem_ge     = (rem_sh >= {1'b0, divisor});
  assign rem_sub    = rem_sh - {1'b0, divisor};
  assign quo_inc    = {1'b0, div_quo_r} + (QUOT_W + 1)'(1);
  assign limit_val  = axis_loop ? (LIMIT_W'(quo_inc) * LIMIT_W'(period))
                                : (LIMIT_W'(period) + LIMIT_W'(axis_area));

  assign sx_step = scroll_x_r + SCROLL_W'(cfg.step);
  assign sy_step = scroll_y_r + SCROLL_W'(cfg.step);

  assign px     = place_origin(cfg.hm, cfg.sw, cfg.aw, scroll_x_r);
  assign py     = place_origin(cfg.vm, cfg.sh, cfg.ah, scroll_y_r);
  assign loop_x = is_loop(cfg.hm);
  assign loop_y = !is_scroll(cfg.hm) && is_loop(cfg.vm);

  assign cp_period = copy_y_r ? $signed(POS_W'(cfg.sh) + POS_W'(cfg.gap))
                              : $signed(POS_W'(cfg.sw) + POS_W'(cfg.gap));
  assign cp_limit  = copy_y_r ? $signed(POS_W'(cfg.ah)) : $signed(POS_W'(cfg.aw));

  // primary and forward copies walk up while below the area edge, then the
  // backward copies walk down from the primary while above zero
  assign more_cap = ((cnt_r + CNT_W'(1)) < CNT_W'(MAX_COPIES));
  assign fwd_ok   = (phase_r != PH_BWD) && (cur_r < cp_limit);
  assign bwd_prim = (phase_r != PH_BWD) && !fwd_ok
                    && !prim_r[POS_W-1] && (prim_r != '0);
  assign bwd_ok   = (phase_r == PH_BWD) && !cur_r[POS_W-1] && (cur_r != '0);
  assign has_next = copy_en_r && more_cap && (fwd_ok || bwd_prim || bwd_ok);
  assign next_pos = fwd_ok   ? (cur_r + cp_period)
                  : bwd_prim ? (prim_r - cp_period)
                  :            (cur_r - cp_period);

  assign ox = copy_y_r ? fix_r : cur_r;
  assign oy = copy_y_r ? cur_r : fix_r;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    div_rem_nxt   = div_rem_r;
    div_num_nxt   = div_num_r;
    div_quo_nxt   = div_quo_r;
    div_cnt_nxt   = div_cnt_r;
    xmax_nxt      = xmax_r;
    ymax_nxt      = ymax_r;
    scroll_x_nxt  = scroll_x_r;
    scroll_y_nxt  = scroll_y_r;
    cur_nxt       = cur_r;
    prim_nxt      = prim_r;
    fix_nxt       = fix_r;
    copy_en_nxt   = copy_en_r;
    copy_y_nxt    = copy_y_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    sy_tmp        = scroll_y_r;
    bf.pop        = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (fb.valid) begin
          bf.pop = 1'b1;
          if (fb.item.step) begin
            axis_nxt    = 1'b0;
            div_rem_nxt = '0;
            div_quo_nxt = '0;
            div_cnt_nxt = '0;
            div_num_nxt = cfg.aw;
            state_nxt   = BK_DIV;
          end else begin
            state_nxt = BK_PLACE;
          end
        end
      end
      BK_DIV: begin
        div_rem_nxt = rem_ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
        div_quo_nxt = {div_quo_r[QUOT_W-2:0], rem_ge};
        div_num_nxt = {div_num_r[AREA_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DCNT_W'(AREA_W - 1)) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        if (!axis_r) begin
          xmax_nxt    = limit_val;
          axis_nxt    = 1'b1;
          div_rem_nxt = '0;
          div_quo_nxt = '0;
          div_cnt_nxt = '0;
          div_num_nxt = cfg.ah;
          state_nxt   = BK_DIV;
        end else begin
          ymax_nxt  = limit_val;
          state_nxt = BK_STEP;
        end
      end
      BK_STEP: begin
        if (is_scroll(cfg.hm)) begin
          scroll_x_nxt = sx_step;
          if (LIMIT_W'(sx_step) > xmax_r) begin
            // horizontal wrap carries into y
            scroll_x_nxt = '0;
            if (is_scroll(cfg.vm)) begin
              sy_tmp = sy_step;
            end
          end
        end else begin
          sy_tmp = sy_step;
        end
        scroll_y_nxt = (LIMIT_W'(sy_tmp) > ymax_r) ? '0 : sy_tmp;
        state_nxt    = BK_PLACE;
      end
      BK_PLACE: begin
        copy_en_nxt = loop_x || loop_y;
        copy_y_nxt  = loop_y;
        cur_nxt     = loop_y ? py : px;
        prim_nxt    = loop_y ? py : px;
        fix_nxt     = loop_y ? px : py;
        phase_nxt   = PH_PRIM;
        cnt_nxt     = '0;
        state_nxt   = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_DATA_W - 2 * ORIGIN_W)'(0),
                           oy[ORIGIN_W-1:0], ox[ORIGIN_W-1:0]};
          out_last_nxt  = !has_next;
          if (has_next) begin
            cur_nxt   = next_pos;
            phase_nxt = fwd_ok ? PH_FWD : PH_BWD;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      scroll_x_r  <= '0;
      scroll_y_r  <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_PRIM;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      scroll_x_r  <= scroll_x_nxt;
      scroll_y_r  <= scroll_y_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r     <= axis_nxt;
    div_rem_r  <= div_rem_nxt;
    div_num_r  <= div_num_nxt;
    div_quo_r  <= div_quo_nxt;
    div_cnt_r  <= div_cnt_nxt;
    xmax_r     <= xmax_nxt;
    ymax_r     <= ymax_nxt;
    cur_r      <= cur_nxt;
    prim_r     <= prim_nxt;
    fix_r      <= fix_nxt;
    copy_en_r  <= copy_en_nxt;
    copy_y_r   <= copy_y_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign stat.idle = (state_r == BK_IDLE);
  assign stat.cnt  = cnt_r;

endmodule

`default_nettype wire

// ===== hdl/marquee_scroll_placer_top.sv =====
// Top level of the marquee scroll placer: configuration registers, front end
// with its item queue, and back end. Depends on msp_pkg, msp_front, msp_back.
//
// Usage: write the eight configuration registers through cfg_we, cfg_index and
// cfg_wdata while the block is idle. Each input item on in_* carries the
// advance flag in in_tdata[0]. For every item the block returns one or more
// strip origins on out_*, the primary origin first and then the looped copy
// origins, at most MAX_COPIES of them; out_tlast marks the final origin.
// Per item: an item that steps the scroll positions passes through two serial
// divides for the x and y loop limits, each followed by a multiply step, then
// step and place, before its first origin; an item that does not step goes
// straight to place. After that one origin leaves per cycle while the receiver
// takes them. The front queue holds two items while the back works.
// Reset restores the register defaults, clears both scroll positions and
// empties the queue. A stalled receiver holds the current origin in the
// output register and the back end waits; the front keeps taking items
// until its queue is full.
`default_nettype none

module marquee_scroll_placer_top import msp_pkg::*; #(
  parameter int MAX_COPIES = MAX_COPIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] advance
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [14:0] origin_x, [29:15] origin_y
  output logic                  out_tlast   // last_copy
);

  localparam cfg_t CFG_RST = '{
    hm:   MODE_CENTER,
    vm:   MODE_CENTER,
    sw:   STRIP_W'(1),
    sh:   STRIP_W'(1),
    aw:   AREA_W'(128),
    ah:   AREA_W'(32),
    step: STEP_W'(2),
    gap:  GAP_W'(10)
  };

  cfg_t     cfg_r, cfg_nxt;
  fb_t      fb;
  bf_t      bf;
  bk_stat_t bk_stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_HORIZ_MODE:   cfg_nxt.hm   = cfg_wdata[MODE_W-1:0];
        REG_VERT_MODE:    cfg_nxt.vm   = cfg_wdata[MODE_W-1:0];
        REG_STRIP_WIDTH:  cfg_nxt.sw   = cfg_wdata[STRIP_W-1:0];
        REG_STRIP_HEIGHT: cfg_nxt.sh   = cfg_wdata[STRIP_W-1:0];
        REG_AREA_WIDTH:   cfg_nxt.aw   = cfg_wdata[AREA_W-1:0];
        REG_AREA_HEIGHT:  cfg_nxt.ah   = cfg_wdata[AREA_W-1:0];
        REG_STEP_SIZE:    cfg_nxt.step = cfg_wdata[STEP_W-1:0];
        REG_LOOP_GAP:     cfg_nxt.gap  = cfg_wdata[GAP_W-1:0];
        default:          cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  msp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .bf        (bf),
    .fb        (fb)
  );

  msp_back #(
    .MAX_COPIES (MAX_COPIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fb         (fb),
    .bf         (bf),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (bk_stat)
  );

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.cnt < CNT_W'(MAX_COPIES))
    else $error("copy index reached the copy cap");

  a_item_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> fb.valid)
    else $error("accepted item missing from queue");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!bk_stat.idle))
    else $error("result raised while back end was idle");

endmodule

`default_nettype wire

// ===== test/tb_marquee_scroll_placer_top.sv =====
// Self-checking testbench for marquee_scroll_placer_top: a directed table, then
// random settings and items, checked against an in-bench placement predictor.
// Depends on msp_pkg and the RTL under hdl/.
module tb_marquee_scroll_placer_top;
  import msp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS  = 415;
  localparam int DIR_N       = 24;

  typedef struct packed {
    logic [ORIGIN_W-1:0] x;
    logic [ORIGIN_W-1:0] y;
    logic                last;
  } origin_t;

  // raw write data, one word per register, in register index order
  typedef struct packed {
    logic [CFG_DATA_W-1:0] hm, vm, sw, sh, aw, ah, step, gap;
  } setting_t;

  typedef struct packed {
    logic                wr;     // load the setting before this item
    setting_t            s;
    logic                adv;
    logic                typed;  // single origin given below
    logic [ORIGIN_W-1:0] ex;
    logic [ORIGIN_W-1:0] ey;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [0] advance
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [14:0] origin_x, [29:15] origin_y
  logic                  out_tlast;  // last_copy

  // register mirror and scroll positions of the predictor
  logic [MODE_W-1:0] cur_hm, cur_vm;
  int unsigned cur_sw, cur_sh, cur_aw, cur_ah, cur_step, cur_gap;
  int unsigned pos_x, pos_y;

  origin_t placed[$];
  origin_t awaited_origins[$];
  origin_t want;

  int errors = 0;
  int items_sent = 0;
  int origins_seen = 0;
  int settings_used = 0;
  int hold_left = 0;
  int sink_pick;
  bit src_free = 1'b0;
  bit sink_free = 1'b0;

  row_t dir_rows [DIR_N] = '{
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 0, 1, 64, 16},          // reset values
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 1, 64, 16},          // no axis scrolls
    '{1, '{1, 1, 4095, 4095, 1024, 1024, 2, 340}, 1, 1, 0, 0},
    '{1, '{2, 2, 4095, 4095, 1, 1, 2, 10}, 0, 1, -4094, -4094},
    '{1, '{0, 0, 4095, 4095, 1024, 1024, 2, 'h1FF}, 0, 1, -1535, -1535},
    '{1, '{2, 2, 0, 0, 'hFFF, 'hFFF, 0, 0}, 1, 1, 2047, 2047},  // masked areas
    '{1, '{3, 3, 8, 6, 20, 12, 7, 0}, 1, 0, 0, 0},
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0},
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0},
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0},
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0},          // x wraps, y steps
    '{1, '{4, 4, 8, 6, 20, 12, 'hFFF, 3}, 1, 0, 0, 0},    // step masked to 31
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0},
    '{1, '{5, 0, 6, 4, 40, 16, 3, 2}, 1, 0, 0, 0},
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0},
    '{1, '{6, 7, 6, 4, 40, 16, 4, 2}, 1, 0, 0, 0},
    '{1, '{7, 5, 5, 4, 33, 16, 6, 1}, 1, 0, 0, 0},        // mode seven on x
    '{1, '{0, 5, 10, 3, 30, 20, 2, 1}, 1, 0, 0, 0},
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0},
    '{1, '{1, 6, 10, 3, 30, 20, 9, 1}, 1, 0, 0, 0},
    '{1, '{3, 5, 10, 3, 30, 20, 4, 1}, 1, 0, 0, 0},       // marquee x hides y copies
    '{1, '{5, 1, 0, 0, 100, 10, 1, 0}, 0, 0, 0, 0},       // zero period
    '{0, '{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0},
    '{1, '{6, 0, 1, 1, 1024, 32, 20, 0}, 1, 0, 0, 0}      // copy cap
  };

  marquee_scroll_placer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned wrap_limit(input logic [MODE_W-1:0] mode,
                                             input int unsigned strip,
                                             input int unsigned area);
    int unsigned period;
    int unsigned divisor;
    period = strip + cur_gap;
    if (mode >= MODE_LOOP) begin
      divisor = (period == 0) ? 1 : period;
      return (area / divisor + 1) * period;
    end
    return period + area;
  endfunction

  function automatic int strip_origin(input logic [MODE_W-1:0] mode, input int strip,
                                      input int area, input int scroll);
    case (mode)
      MODE_CENTER: return area / 2 - strip / 2;
      MODE_START: return 0;
      MODE_END: return area - strip;
      MODE_MARQUEE, MODE_LOOP: return area - scroll;
      default: return scroll - strip;
    endcase
  endfunction

  function automatic void add_origin(input int x, input int y);
    placed.push_back('{x: x[ORIGIN_W-1:0], y: y[ORIGIN_W-1:0], last: 1'b0});
  endfunction

  // Step the scroll positions if asked, then list the primary and looped origins.
  task automatic place_strips(input bit adv);
    logic [MODE_W-1:0] hm, vm;
    int unsigned lim_x, lim_y;
    int px, py, pos, period, bound;
    origin_t tail;
    placed.delete();
    hm = (cur_hm == MODE_ALIAS) ? MODE_RLOOP : cur_hm;
    vm = (cur_vm == MODE_ALIAS) ? MODE_RLOOP : cur_vm;
    if (adv && (hm >= MODE_MARQUEE || vm >= MODE_MARQUEE)) begin
      lim_y = wrap_limit(vm, cur_sh, cur_ah);
      lim_x = wrap_limit(hm, cur_sw, cur_aw);
      if (hm >= MODE_MARQUEE) begin
        pos_x = (pos_x + cur_step) & 32'h1FFF;
        if (pos_x > lim_x) begin
          pos_x = 0;
          if (vm >= MODE_MARQUEE) pos_y = (pos_y + cur_step) & 32'h1FFF;
        end
      end else begin
        pos_y = (pos_y + cur_step) & 32'h1FFF;
      end
      if (pos_y > lim_y) pos_y = 0;
    end
    px = strip_origin(hm, cur_sw, cur_aw, pos_x);
    py = strip_origin(vm, cur_sh, cur_ah, pos_y);
    add_origin(px, py);
    if (hm >= MODE_LOOP) begin
      period = cur_sw + cur_gap;
      bound = cur_aw;
      pos = px;
      while (placed.size() < MAX_COPIES_DEF && pos < bound) begin
        pos += period;
        add_origin(pos, py);
      end
      pos = px;
      while (placed.size() < MAX_COPIES_DEF && pos > 0) begin
        pos -= period;
        add_origin(pos, py);
      end
    end else if (hm < MODE_MARQUEE && vm >= MODE_LOOP) begin
      period = cur_sh + cur_gap;
      bound = cur_ah;
      pos = py;
      while (placed.size() < MAX_COPIES_DEF && pos < bound) begin
        pos += period;
        add_origin(px, pos);
      end
      pos = py;
      while (placed.size() < MAX_COPIES_DEF && pos > 0) begin
        pos -= period;
        add_origin(px, pos);
      end
    end
    tail = placed.pop_back();
    tail.last = 1'b1;
    placed.push_back(tail);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HORIZ_MODE: cur_hm = val[MODE_W-1:0];
      REG_VERT_MODE: cur_vm = val[MODE_W-1:0];
      REG_STRIP_WIDTH: cur_sw = 32'(val[STRIP_W-1:0]);
      REG_STRIP_HEIGHT: cur_sh = 32'(val[STRIP_W-1:0]);
      REG_AREA_WIDTH: cur_aw = 32'(val[AREA_W-1:0]);
      REG_AREA_HEIGHT: cur_ah = 32'(val[AREA_W-1:0]);
      REG_STEP_SIZE: cur_step = 32'(val[STEP_W-1:0]);
      default: cur_gap = 32'(val[GAP_W-1:0]);
    endcase
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_HORIZ_MODE, s.hm);
    write_reg(REG_VERT_MODE, s.vm);
    write_reg(REG_STRIP_WIDTH, s.sw);
    write_reg(REG_STRIP_HEIGHT, s.sh);
    write_reg(REG_AREA_WIDTH, s.aw);
    write_reg(REG_AREA_HEIGHT, s.ah);
    write_reg(REG_STEP_SIZE, s.step);
    write_reg(REG_LOOP_GAP, s.gap);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Drop valid, let every awaited origin arrive, then let the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_origins.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input bit adv, input bit typed, input logic [ORIGIN_W-1:0] ex,
                           input logic [ORIGIN_W-1:0] ey);
    int gap;
    int r;
    r = int'($urandom_range(0, 19));
    if (src_free || r < 12) gap = 0;
    else if (r < 18) gap = int'($urandom_range(1, 3));
    else gap = int'($urandom_range(10, 40));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'(adv);
    do @(posedge clk); while (!in_tready);
    place_strips(adv);
    if (typed) awaited_origins.push_back('{x: ex, y: ey, last: 1'b1});
    else foreach (placed[i]) awaited_origins.push_back(placed[i]);
    items_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (sink_free) begin
      out_tready <= 1'b1;
    end else begin
      sink_pick = int'($urandom_range(0, 19));
      if (sink_pick < 13) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        hold_left = (sink_pick < 18) ? int'($urandom_range(0, 2))
                                     : int'($urandom_range(10, 40));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      origins_seen++;
      if (awaited_origins.size() == 0) begin
        $error("origin with none expected: x=%0d y=%0d last=%0b",
               $signed(out_tdata[ORIGIN_W-1:0]), $signed(out_tdata[2*ORIGIN_W-1:ORIGIN_W]),
               out_tlast);
        errors++;
      end else begin
        want = awaited_origins.pop_front();
        if (out_tdata[ORIGIN_W-1:0] !== want.x) begin
          $error("origin_x expected %0d got %0d", $signed(want.x),
                 $signed(out_tdata[ORIGIN_W-1:0]));
          errors++;
        end
        if (out_tdata[2*ORIGIN_W-1:ORIGIN_W] !== want.y) begin
          $error("origin_y expected %0d got %0d", $signed(want.y),
                 $signed(out_tdata[2*ORIGIN_W-1:ORIGIN_W]));
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_copy expected %0b got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    setting_t s;
    int batch;
    int dir_items;
    bit adv;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cur_hm = MODE_CENTER;
    cur_vm = MODE_CENTER;
    cur_sw = 1;
    cur_sh = 1;
    cur_aw = 128;
    cur_ah = 32;
    cur_step = 2;
    cur_gap = 10;
    pos_x = 0;
    pos_y = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        wait_idle();
        apply_setting(dir_rows[i].s);
      end
      send_item(dir_rows[i].adv, dir_rows[i].typed, dir_rows[i].ex, dir_rows[i].ey);
    end
    dir_items = items_sent;

    while (items_sent < dir_items + RAND_ITEMS) begin
      wait_idle();
      s.hm = 12'($urandom_range(0, 7));
      s.vm = 12'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) begin
        // wide-range sizes, with a dense loop now and then
        s.sw = 12'($urandom_range(1, 4095));
        s.sh = 12'($urandom_range(1, 4095));
        s.aw = 12'($urandom_range(1, 1024));
        s.ah = 12'($urandom_range(1, 1024));
        s.gap = 12'($urandom_range(0, 340));
        if ($urandom_range(0, 1) == 1) begin
          s.sw = 12'($urandom_range(1, 3));
          s.aw = 12'd1024;
          s.gap = '0;
        end
      end else begin
        // small sizes so the positions wrap often
        s.sw = 12'($urandom_range(1, 40));
        s.sh = 12'($urandom_range(1, 24));
        s.aw = 12'($urandom_range(1, 64));
        s.ah = 12'($urandom_range(1, 32));
        s.gap = 12'($urandom_range(0, 16));
      end
      s.step = 12'($urandom_range(1, 20));
      if ($urandom_range(0, 9) == 0) s.step = 12'($urandom());
      if ($urandom_range(0, 14) == 0) s.gap = 12'($urandom());
      apply_setting(s);
      src_free = ($urandom_range(0, 3) == 0);
      sink_free = ($urandom_range(0, 3) == 0);
      batch = int'($urandom_range(12, 30));
      repeat (batch) begin
        adv = ($urandom_range(0, 4) != 0);
        send_item(adv, 1'b0, '0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (awaited_origins.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d items (%0d from the table) through %0d register settings,",
             items_sent, dir_items, settings_used);
    $display("checking %0d strip origins.", origins_seen);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
